// ----- hw/rtl/ptbl_pkg.sv -----
// Shared types, constants and reset tables of the priority token bucket limiter.
`timescale 1ns / 1ps

package ptbl_pkg;

  // Bucket geometry
  localparam int LEVELS        = 5;
  localparam int TOKEN_BITS    = 16;
  localparam int RATE_BITS     = 16;
  localparam int EL_BITS       = 16;
  localparam int LV_W          = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEFAULT_LEVEL = (2 < LEVELS) ? 2 : LEVELS - 1;

  // Configuration port geometry
  localparam int RATE_REGS = 5;
  localparam int REG_W     = $clog2(RATE_REGS);
  localparam int ADDR_W    = REG_W + 2;
  localparam int DATA_W    = 32;

  // Stream payload widths
  localparam int CMD_W       = 2;
  localparam int PRIO_W      = 3;
  localparam int PERMIT_W    = 16;
  localparam int OUT_TOK_W   = 16;
  localparam int IN_FIELDS_W = CMD_W + PRIO_W + PERMIT_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + OUT_TOK_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Shared unit datapath
  localparam int ALU_W  = 32;
  localparam int PROD_W = RATE_BITS + EL_BITS;
  // floor(p / 1000) = floor((p >> 3) * RECIP >> RECIP_SHIFT), exact for p < 2^32
  localparam int DIV_PRE_SHIFT = 3;
  localparam int RECIP_SHIFT   = 36;
  localparam longint RECIP_MUL = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
  localparam int ADD_W = PROD_W - 9;  // quotient below 2^32 / 1000
  localparam logic [EL_BITS-1:0] EL_MAX = '1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RAW,
    ST_MUL_RECIP,
    ST_REFILL,
    ST_TAKE,
    ST_DONE
  } state_t;

  // Shared unit operations
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADDCAP,
    ALU_SUBGE,
    ALU_NOP
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
    logic [ALU_W-1:0]   cap;
  } alu_req_t;

  typedef struct packed {
    logic [2*ALU_W-1:0] res;
    logic               flag;
  } alu_rsp_t;

  // Reset rate of a level
  function automatic logic [RATE_BITS-1:0] reset_rate(input int lv);
    logic [RATE_BITS-1:0] r;
    unique case (lv)
      0:       r = RATE_BITS'(10000);
      1:       r = RATE_BITS'(5000);
      2:       r = RATE_BITS'(1000);
      3:       r = RATE_BITS'(500);
      default: r = RATE_BITS'(100);
    endcase
    return r;
  endfunction

  // Reset burst and token count of a level
  function automatic logic [TOKEN_BITS-1:0] reset_burst(input int lv);
    logic [TOKEN_BITS-1:0] b;
    unique case (lv)
      0:       b = TOKEN_BITS'(10000);
      1:       b = TOKEN_BITS'(5000);
      2:       b = TOKEN_BITS'(2000);
      3:       b = TOKEN_BITS'(1000);
      default: b = TOKEN_BITS'(500);
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/ptbl_alu.sv -----
// Shared arithmetic unit: multiply, add with cap, compare and subtract.
`timescale 1ns / 1ps

module ptbl_alu (
  input  ptbl_pkg::alu_req_t req,
  output ptbl_pkg::alu_rsp_t rsp
);
  import ptbl_pkg::*;

  logic [ALU_W:0] sum;

  always_comb begin
    sum      = {1'b0, req.a} + {1'b0, req.b};
    rsp.res  = '0;
    rsp.flag = 1'b0;
    unique case (req.op)
      // Full product of the two 32-bit operands
      ALU_MUL: begin
        rsp.res = (2*ALU_W)'(req.a) * (2*ALU_W)'(req.b);
      end
      // Add and clamp at the cap
      ALU_ADDCAP: begin
        if (sum > {1'b0, req.cap}) begin
          rsp.res = (2*ALU_W)'(req.cap);
        end else begin
          rsp.res = (2*ALU_W)'(sum);
        end
      end
      // Subtract only when a covers b
      ALU_SUBGE: begin
        if (req.a >= req.b) begin
          rsp.res  = (2*ALU_W)'(req.a - req.b);
          rsp.flag = 1'b1;
        end else begin
          rsp.res  = (2*ALU_W)'(req.a);
        end
      end
      default: begin
        rsp.res = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/priority_token_bucket_limiter_top.sv -----
// Top level: bucket state, sequencer, stream and configuration ports.
// Acquire: the sequencer steps one shared multiplier/adder/comparer through 4 steps
//   (raw multiply, reciprocal multiply, refill, take), then loads the result beat.
// Tick and query go straight to the result beat. A new beat is accepted only in idle.
// The output register lets the next beat be accepted while a result waits.
// Synchronous active-low reset loads the default rates, bursts and token counts
//   and clears all elapsed counters; the block is ready right after reset.
`timescale 1ns / 1ps

module priority_token_bucket_limiter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: command[1:0], priority_req[4:2], permits[20:5], zero pad above
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ptbl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: granted[0], tokens_left[16:1], zero pad above
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ptbl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ptbl_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [ptbl_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [ptbl_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import ptbl_pkg::*;

  // Bucket state
  logic [RATE_BITS-1:0]  rate_r  [LEVELS];
  logic [TOKEN_BITS-1:0] tok_r   [LEVELS];
  logic [TOKEN_BITS-1:0] burst_r [LEVELS];
  logic [EL_BITS-1:0]    el_r    [LEVELS];

  // Item and sequencer registers
  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [LV_W-1:0]       lv_r;
  logic [PERMIT_W-1:0]   permits_r;
  logic [PROD_W-1:0]     prod_r;
  logic [ADD_W-1:0]      add_r;
  logic                  grant_r;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  logic                  in_fire;
  cmd_t                  in_cmd;
  logic [PRIO_W-1:0]     in_prio;
  logic [LV_W-1:0]       in_lv;
  logic                  out_load;
  logic                  cfg_wr;
  logic [REG_W-1:0]      cfg_idx;
  logic                  cfg_hit;
  logic [LV_W-1:0]       cfg_lv;

  // Unpack the input beat and map the priority onto a level
  assign in_cmd  = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_prio = in_tdata[CMD_W +: PRIO_W];
  assign in_lv   = (32'(in_prio) < LEVELS) ? LV_W'(in_prio) : LV_W'(DEFAULT_LEVEL);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Configuration decode
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_hit    = (32'(cfg_idx) < LEVELS);
  assign cfg_lv     = LV_W'(cfg_idx);
  assign cfg_prdata = cfg_hit ? DATA_W'(rate_r[cfg_lv]) : '0;

  ptbl_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Sequencer: next state and shared unit operands
  always_comb begin
    state_nxt   = state_r;
    alu_req.op  = ALU_NOP;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.cap = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_cmd == CMD_ACQUIRE) ? ST_MUL_RAW : ST_DONE;
        end
      end
      ST_MUL_RAW: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(el_r[lv_r]);
        alu_req.b  = ALU_W'(rate_r[lv_r]);
        state_nxt  = ST_MUL_RECIP;
      end
      ST_MUL_RECIP: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(prod_r >> DIV_PRE_SHIFT);
        alu_req.b  = ALU_W'(RECIP_MUL);
        state_nxt  = ST_REFILL;
      end
      ST_REFILL: begin
        alu_req.op  = ALU_ADDCAP;
        alu_req.a   = ALU_W'(tok_r[lv_r]);
        alu_req.b   = ALU_W'(add_r);
        alu_req.cap = ALU_W'(burst_r[lv_r]);
        state_nxt   = ST_TAKE;
      end
      ST_TAKE: begin
        alu_req.op = ALU_SUBGE;
        alu_req.a  = ALU_W'(tok_r[lv_r]);
        alu_req.b  = ALU_W'(permits_r);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item and the shared unit results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_cmd;
      lv_r      <= in_lv;
      permits_r <= in_tdata[CMD_W+PRIO_W +: PERMIT_W];
      grant_r   <= 1'b0;
    end
    if (state_r == ST_MUL_RAW) begin
      prod_r <= alu_rsp.res[PROD_W-1:0];
    end
    if (state_r == ST_MUL_RECIP) begin
      add_r <= alu_rsp.res[RECIP_SHIFT +: ADD_W];
    end
    if (state_r == ST_TAKE) begin
      grant_r <= alu_rsp.flag;
    end
  end

  // Bucket state: reset, rate writes, ticks, refill and take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        rate_r[i]  <= reset_rate(i);
        burst_r[i] <= reset_burst(i);
        tok_r[i]   <= reset_burst(i);
        el_r[i]    <= '0;
      end
    end else begin
      if (cfg_wr && cfg_hit) begin
        rate_r[cfg_lv]  <= cfg_pwdata[RATE_BITS-1:0];
        burst_r[cfg_lv] <= TOKEN_BITS'(cfg_pwdata[RATE_BITS-1:0]);
        tok_r[cfg_lv]   <= TOKEN_BITS'(cfg_pwdata[RATE_BITS-1:0]);
        el_r[cfg_lv]    <= '0;
      end
      if (in_fire && (in_cmd == CMD_TICK)) begin
        for (int i = 0; i < LEVELS; i++) begin
          if (el_r[i] != EL_MAX) begin
            el_r[i] <= el_r[i] + EL_BITS'(1);
          end
        end
      end
      if ((state_r == ST_REFILL) && (add_r != '0)) begin
        tok_r[lv_r] <= alu_rsp.res[TOKEN_BITS-1:0];
        el_r[lv_r]  <= '0;
      end
      if (state_r == ST_TAKE) begin
        tok_r[lv_r] <= alu_rsp.res[TOKEN_BITS-1:0];
      end
    end
  end

  // Output register: load the result beat, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_TDATA_W'({OUT_TOK_W'(tok_r[lv_r]), grant_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted acquire starts the multiply step
  a_acq_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_ACQUIRE) |=> state_r == ST_MUL_RAW)
    else $error("acquire did not start the refill sequence");

  // A refill that adds tokens clears the elapsed counter
  a_refill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFILL) && (add_r != '0) |=> el_r[lv_r] == '0)
    else $error("elapsed counter not cleared after refill");

  // Tokens never exceed the burst of the bucket being reported
  a_tok_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> tok_r[lv_r] <= burst_r[lv_r])
    else $error("token count above burst");

  // A stalled result keeps the sequencer waiting
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_tvalid_r && !out_tready |=> state_r == ST_DONE)
    else $error("result dropped while output stalled");

  // Only an acquire can report a grant
  a_grant_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && grant_r |-> cmd_r == CMD_ACQUIRE)
    else $error("grant on a non-acquire item");

endmodule
